/* design/grc_pkg.sv */
// ----------------------------------------------------------------------------
// grc_pkg
// Shared constants and types of the grid column raycaster.
// ----------------------------------------------------------------------------
package grc_pkg;

	localparam int MAP_WIDTH        = 16;
	localparam int MAP_HEIGHT       = 16;
	localparam int SINE_TABLE_DEPTH = 1024;

	localparam int MAP_CELLS = MAP_WIDTH * MAP_HEIGHT;
	localparam int CELL_W    = $clog2(MAP_CELLS);

	localparam int STEP_Q8  = 26;
	localparam int CEIL_MAG = 2560;

	// Bhaskara denominator base 5*H^2 (H = table depth in doubled index units)
	localparam longint SIN_DEN_BASE = 5 * SINE_TABLE_DEPTH * SINE_TABLE_DEPTH;

	localparam int DIV_W     = 42;
	localparam int DIV_CNT_W = 6;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;

	localparam logic [2:0] CFG_POS_X         = 3'd0;
	localparam logic [2:0] CFG_POS_Y         = 3'd1;
	localparam logic [2:0] CFG_VIEW_ANGLE    = 3'd2;
	localparam logic [2:0] CFG_FIELD_OF_VIEW = 3'd3;
	localparam logic [2:0] CFG_VIEW_RADIUS   = 3'd4;
	localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd5;
	localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd6;

	localparam logic REQ_RENDER = 1'b0;
	localparam logic REQ_MAP    = 1'b1;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [11:0] view_angle;
		logic [11:0] field_of_view;
		logic [15:0] view_radius;
		logic [10:0] screen_width;
		logic [8:0]  screen_height;
	} cfg_t;

	typedef struct packed {
		logic               req_type;
		logic [9:0]         column;
		logic [7:0]         cell_index;
		logic               cell_wall;
		logic signed [15:0] sine;
		logic signed [15:0] cosine;
	} job_t;

endpackage

/* design/grid_raycast_column.sv */
// ----------------------------------------------------------------------------
// grid_raycast_column
// Column raycaster over a one-bit wall map.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): req_type 1 writes cell_index with
// cell_wall and gives no result; req_type 0 renders one column and gives one
// result on the output channel (out_valid/out_stall) with the ceiling row,
// floor row and Q8.8 wall distance. Items complete in order.
// Configuration: cfg_valid/cfg_ready write cfg_data into register cfg_index;
// cfg_ready is always high. Write only while the block is idle.
// Flow of a render: the front forms the angle, sine and cosine with three
// divisions in turn, then queues the job; the back marches in 26/256
// steps, up to view_radius/26 steps rounded up (158 at reset values), then
// runs the ceiling division and registers the result.
// The front takes no new item until its last render is queued; map writes
// go straight into the queue and are written when the back pops them.
// A four-entry queue separates front and back; while out_stall holds the
// result, the back may march on but waits before loading its next result,
// and the front keeps filling the queue. Reset loads the default registers;
// the back then clears all 256 map cells before it takes the first queued item.
// ----------------------------------------------------------------------------
module grid_raycast_column (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [9:0]         column,
	input  logic [7:0]         cell_index,
	input  logic               cell_wall,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [9:0]         out_column,
	output logic signed [12:0] ceiling_row,
	output logic signed [12:0] floor_row,
	output logic [15:0]        wall_distance,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	grc_pkg::cfg_t cfg_q;
	grc_pkg::job_t push_data;
	grc_pkg::job_t head;
	logic          push;
	logic          pop;
	logic          full;
	logic          empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x         <= 16'd2048;
			cfg_q.pos_y         <= 16'd2048;
			cfg_q.view_angle    <= 12'd0;
			cfg_q.field_of_view <= 12'd512;
			cfg_q.view_radius   <= 16'd4096;
			cfg_q.screen_width  <= 11'd120;
			cfg_q.screen_height <= 9'd40;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				grc_pkg::CFG_POS_X:         cfg_q.pos_x         <= cfg_data;
				grc_pkg::CFG_POS_Y:         cfg_q.pos_y         <= cfg_data;
				grc_pkg::CFG_VIEW_ANGLE:    cfg_q.view_angle    <= cfg_data[11:0];
				grc_pkg::CFG_FIELD_OF_VIEW: cfg_q.field_of_view <= cfg_data[11:0];
				grc_pkg::CFG_VIEW_RADIUS:   cfg_q.view_radius   <= cfg_data;
				grc_pkg::CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[10:0];
				grc_pkg::CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	grc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.column     (column),
		.cell_index (cell_index),
		.cell_wall  (cell_wall),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	grc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	grc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_column    (out_column),
		.ceiling_row   (ceiling_row),
		.floor_row     (floor_row),
		.wall_distance (wall_distance)
	);

endmodule

/* design/grc_div.sv */
// ----------------------------------------------------------------------------
// grc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [grc_pkg::DIV_W-1:0]  dividend,
	input  logic [grc_pkg::DIV_W-1:0]  divisor,
	output logic                       busy,
	output logic                       done,
	output logic [grc_pkg::DIV_W-1:0]  quotient
);

	logic [grc_pkg::DIV_W-1:0]     quo_q;
	logic [grc_pkg::DIV_W-1:0]     rem_q;
	logic [grc_pkg::DIV_W-1:0]     den_q;
	logic [grc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [grc_pkg::DIV_W:0]       trial;
	logic [grc_pkg::DIV_W:0]       diff;
	logic                          ge;

	always_comb begin
		trial = {rem_q, quo_q[grc_pkg::DIV_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= grc_pkg::DIV_CNT_W'(grc_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == grc_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[grc_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? diff[grc_pkg::DIV_W-1:0] : trial[grc_pkg::DIV_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* design/grc_fifo.sv */
// ----------------------------------------------------------------------------
// grc_fifo
// Short job queue between the front and back parts, show-ahead head.
// ----------------------------------------------------------------------------
module grc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  grc_pkg::job_t push_data,
	input  logic          pop,
	output grc_pkg::job_t head,
	output logic          full,
	output logic          empty
);

	grc_pkg::job_t                 mem_q [grc_pkg::FIFO_DEPTH];
	logic [grc_pkg::FIFO_PTR_W-1:0] wr_q;
	logic [grc_pkg::FIFO_PTR_W-1:0] rd_q;
	logic [grc_pkg::FIFO_PTR_W:0]   cnt_q;

	assign full  = cnt_q == (grc_pkg::FIFO_PTR_W+1)'(grc_pkg::FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue push while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue pop while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (grc_pkg::FIFO_PTR_W+1)'(grc_pkg::FIFO_DEPTH))
		else $error("queue count out of range");

endmodule

/* design/grc_front.sv */
// ----------------------------------------------------------------------------
// grc_front
// Accepts items, forms the ray angle and its sine and cosine, queues jobs.
// ----------------------------------------------------------------------------
module grc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  grc_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          req_type,
	input  logic [9:0]    column,
	input  logic [7:0]    cell_index,
	input  logic          cell_wall,
	output logic          push,
	output grc_pkg::job_t push_data,
	input  logic          full
);

	typedef enum logic [2:0] {
		F_IDLE, F_QDIV, F_QWAIT, F_IDX, F_PROD, F_TDIV, F_TWAIT, F_PUSH
	} fstate_t;

	fstate_t                  state_q;
	logic                     phase_q;
	logic [9:0]               column_q;
	logic [11:0]              ang_q;
	logic [13:0]              u_q;
	logic                     neg_q;
	logic [23:0]              p_q;
	logic signed [15:0]       sine_q;
	logic signed [15:0]       cosine_q;

	logic                     accept;
	logic                     div_start;
	logic [grc_pkg::DIV_W-1:0] div_a;
	logic [grc_pkg::DIV_W-1:0] div_b;
	logic                     div_busy;
	logic                     div_done;
	logic [grc_pkg::DIV_W-1:0] div_q;
	logic [10:0]              w_eff;
	logic [11:0]              ang_sel;
	logic [24:0]              idx_prod;
	logic [13:0]              u_raw;
	logic [13:0]              u_fold;
	logic signed [15:0]       trig;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != F_IDLE) || full;

	always_comb begin
		w_eff    = (cfg.screen_width == '0) ? 11'd1 : cfg.screen_width;
		ang_sel  = phase_q ? (ang_q + 12'd1024) : ang_q;
		idx_prod = 25'(ang_sel) * 25'(grc_pkg::SINE_TABLE_DEPTH);
		u_raw    = {idx_prod[24:12], 1'b0};
		u_fold   = (u_raw >= 14'(grc_pkg::SINE_TABLE_DEPTH))
			? u_raw - 14'(grc_pkg::SINE_TABLE_DEPTH) : u_raw;
		trig     = neg_q ? -$signed(div_q[15:0]) : $signed(div_q[15:0]);
		div_start = (state_q == F_QDIV) || (state_q == F_TDIV);
		if (state_q == F_QDIV) begin
			div_a = grc_pkg::DIV_W'(22'(column_q) * 22'(cfg.field_of_view));
			div_b = grc_pkg::DIV_W'(w_eff);
		end else begin
			div_a = {p_q, 18'b0};
			div_b = grc_pkg::DIV_W'(grc_pkg::SIN_DEN_BASE) - grc_pkg::DIV_W'({p_q, 2'b0});
		end
	end

	always_comb begin
		push = 1'b0;
		push_data.req_type   = req_type;
		push_data.column     = column;
		push_data.cell_index = cell_index;
		push_data.cell_wall  = cell_wall;
		push_data.sine       = '0;
		push_data.cosine     = '0;
		if (state_q == F_PUSH) begin
			push = !full;
			push_data.req_type = grc_pkg::REQ_RENDER;
			push_data.column   = column_q;
			push_data.sine     = sine_q;
			push_data.cosine   = cosine_q;
		end else if (accept && req_type == grc_pkg::REQ_MAP) begin
			push = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			phase_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept && req_type == grc_pkg::REQ_RENDER) begin
						column_q <= column;
						phase_q  <= 1'b0;
						state_q  <= F_QDIV;
					end
				end
				F_QDIV: state_q <= F_QWAIT;
				F_QWAIT: begin
					if (div_done) begin
						ang_q   <= cfg.view_angle - cfg.field_of_view[11:1] + div_q[11:0];
						state_q <= F_IDX;
					end
				end
				F_IDX: begin
					u_q     <= u_fold;
					neg_q   <= u_raw >= 14'(grc_pkg::SINE_TABLE_DEPTH);
					state_q <= F_PROD;
				end
				F_PROD: begin
					p_q     <= 24'(28'(u_q) * 28'(14'(grc_pkg::SINE_TABLE_DEPTH) - u_q));
					state_q <= F_TDIV;
				end
				F_TDIV: state_q <= F_TWAIT;
				F_TWAIT: begin
					if (div_done) begin
						if (!phase_q) begin
							sine_q  <= trig;
							phase_q <= 1'b1;
							state_q <= F_IDX;
						end else begin
							cosine_q <= trig;
							state_q  <= F_PUSH;
						end
					end
				end
				F_PUSH: if (!full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	grc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("front divider restarted while busy");
	a_wait_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_QDIV) |=> div_busy)
		else $error("front divider did not start");
	a_idle_no_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_IDLE) |-> !div_busy)
		else $error("front divider busy while idle");

endmodule

/* design/grc_back.sv */
// ----------------------------------------------------------------------------
// grc_back
// Owns the wall map, marches rays and computes the column span.
// ----------------------------------------------------------------------------
module grc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  grc_pkg::cfg_t      cfg,
	input  grc_pkg::job_t      head,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [9:0]         out_column,
	output logic signed [12:0] ceiling_row,
	output logic signed [12:0] floor_row,
	output logic [15:0]        wall_distance
);

	typedef enum logic [3:0] {
		B_CLR, B_IDLE, B_MARCH, B_TEST, B_SAT, B_MUL, B_DIV, B_WAIT, B_RES
	} bstate_t;

	bstate_t                   state_q;
	logic                      map_q [grc_pkg::MAP_CELLS];
	logic [grc_pkg::CELL_W-1:0] clr_q;
	logic                      wall_q;
	logic                      leave_q;
	logic [9:0]                column_q;
	logic signed [32:0]        acc_x_q;
	logic signed [32:0]        acc_y_q;
	logic signed [32:0]        stp_x_q;
	logic signed [32:0]        stp_y_q;
	logic [16:0]               dist_q;
	logic [15:0]               dist_s_q;
	logic signed [26:0]        num_q;
	logic                      zero_q;
	logic                      out_valid_q;

	logic signed [32:0]        sx;
	logic signed [32:0]        sy;
	logic signed [32:0]        ax_n;
	logic signed [32:0]        ay_n;
	logic [16:0]               dist_n;
	logic                      out_x;
	logic                      out_y;
	logic [10:0]               cx;
	logic [10:0]               cy;
	logic [grc_pkg::CELL_W-1:0] cidx;
	logic                      map_we;
	logic [grc_pkg::CELL_W-1:0] map_wa;
	logic                      map_wd;
	logic                      can_load;
	logic                      res_load;
	logic                      div_start;
	logic                      div_busy;
	logic                      div_done;
	logic [grc_pkg::DIV_W-1:0] div_a;
	logic [grc_pkg::DIV_W-1:0] div_b;
	logic [grc_pkg::DIV_W-1:0] div_q;
	logic signed [12:0]        ceil_c;

	assign pop = (state_q == B_IDLE) && !empty;

	always_comb begin
		sx     = 33'(head.sine);
		sy     = 33'(head.cosine);
		dist_n = dist_q + 17'(grc_pkg::STEP_Q8);
		ax_n   = acc_x_q + stp_x_q;
		ay_n   = acc_y_q + stp_y_q;
		out_x  = (ax_n < -33'sd4194303) ||
			(!ax_n[32] && ax_n[32:22] >= 11'(grc_pkg::MAP_WIDTH));
		out_y  = (ay_n < -33'sd4194303) ||
			(!ay_n[32] && ay_n[32:22] >= 11'(grc_pkg::MAP_HEIGHT));
		cx     = ax_n[32] ? 11'd0 : ax_n[32:22];
		cy     = ay_n[32] ? 11'd0 : ay_n[32:22];
		cidx   = grc_pkg::CELL_W'(17'(cy) * 17'(grc_pkg::MAP_WIDTH) + 17'(cx));
		map_we = (state_q == B_CLR) ||
			(pop && head.req_type == grc_pkg::REQ_MAP &&
			9'(head.cell_index) < 9'(grc_pkg::MAP_CELLS));
		map_wa = (state_q == B_CLR) ? clr_q : grc_pkg::CELL_W'(head.cell_index);
		map_wd = (state_q == B_CLR) ? 1'b0 : head.cell_wall;
		can_load = !out_valid_q || !out_stall;
		res_load = (state_q == B_RES) && can_load;
		div_start = state_q == B_DIV;
		div_a  = grc_pkg::DIV_W'(num_q[26] ? -num_q : num_q);
		div_b  = grc_pkg::DIV_W'({dist_s_q, 1'b0});
		if (zero_q) begin
			ceil_c = -13'sd2560;
		end else if (num_q[26]) begin
			ceil_c = (div_q > grc_pkg::DIV_W'(grc_pkg::CEIL_MAG))
				? -13'sd2560 : -$signed(div_q[12:0]);
		end else begin
			ceil_c = $signed(div_q[12:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) map_q[map_wa] <= map_wd;
		wall_q <= map_q[cidx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == grc_pkg::CELL_W'(grc_pkg::MAP_CELLS - 1))
						state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (!empty && head.req_type == grc_pkg::REQ_RENDER) begin
						column_q <= head.column;
						acc_x_q  <= {3'b0, cfg.pos_x, 14'b0};
						acc_y_q  <= {3'b0, cfg.pos_y, 14'b0};
						stp_x_q  <= (sx <<< 4) + (sx <<< 3) + (sx <<< 1);
						stp_y_q  <= (sy <<< 4) + (sy <<< 3) + (sy <<< 1);
						dist_q   <= '0;
						state_q  <= B_MARCH;
					end
				end
				B_MARCH: begin
					if (dist_q >= 17'(cfg.view_radius)) begin
						dist_q  <= 17'(cfg.view_radius);
						state_q <= B_SAT;
					end else begin
						dist_q  <= dist_n;
						acc_x_q <= ax_n;
						acc_y_q <= ay_n;
						leave_q <= out_x || out_y;
						state_q <= B_TEST;
					end
				end
				B_TEST: begin
					if (leave_q) begin
						dist_q  <= 17'(cfg.view_radius);
						state_q <= B_SAT;
					end else if (wall_q) begin
						state_q <= B_SAT;
					end else begin
						state_q <= B_MARCH;
					end
				end
				B_SAT: begin
					dist_s_q <= dist_q[16] ? 16'hFFFF : dist_q[15:0];
					state_q  <= B_MUL;
				end
				B_MUL: begin
					num_q   <= 27'(25'(cfg.screen_height) * 25'(dist_s_q))
						- 27'({cfg.screen_height, 9'b0});
					zero_q  <= dist_s_q == '0;
					state_q <= (dist_s_q == '0) ? B_RES : B_DIV;
				end
				B_DIV: state_q <= B_WAIT;
				B_WAIT: if (div_done) state_q <= B_RES;
				B_RES: begin
					if (can_load) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_column    <= column_q;
			ceiling_row   <= ceil_c;
			floor_row     <= $signed(13'(cfg.screen_height)) - ceil_c;
			wall_distance <= dist_s_q;
		end
	end

	assign out_valid = out_valid_q;

	grc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	a_march_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_MARCH) |-> (dist_q < 17'(cfg.view_radius) + 17'(grc_pkg::STEP_Q8)))
		else $error("march ran past radius");
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("back divider restarted while busy");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == B_IDLE || state_q == B_MARCH))
		else $error("unexpected state after pop");

endmodule
